[src/lcdnw_pkg.sv]
// Shared types, codes and constants for the character LCD nibble writer.
`default_nettype none
package lcdnw_pkg;

   typedef enum logic [1:0] {
      OP_POS_CHAR    = 2'd0,
      OP_RAW_CTRL    = 2'd1,
      OP_STREAM_CHAR = 2'd2,
      OP_UNUSED      = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_LINE_TWO_START = 2'd0,
      CSR_LINE_ONE_BASE  = 2'd1,
      CSR_LINE_TWO_BASE  = 2'd2,
      CSR_NONE           = 2'd3
   } csr_index_type;

   localparam int BYTE_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int WAIT_W      = 6;
   localparam int PHASE_W     = 3;
   localparam int CSR_INDEX_W = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 1;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [BYTE_W-1:0] LINE_TWO_START_RESET = 8'd8;
   localparam logic [BYTE_W-1:0] LINE_ONE_BASE_RESET  = 8'd128;
   localparam logic [BYTE_W-1:0] LINE_TWO_BASE_RESET  = 8'd192;
   localparam logic [BYTE_W-1:0] CURSOR_RESET         = 8'hFF;

   localparam logic [BYTE_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [WAIT_W-1:0] WAIT_NONE  = 6'd0;
   localparam logic [WAIT_W-1:0] WAIT_SHORT = 6'd1;
   localparam logic [WAIT_W-1:0] WAIT_LONG  = 6'd40 + 6'd1;

   localparam logic [PHASE_W-1:0] PHASE_ADDR_FIRST = 3'd0;
   localparam logic [PHASE_W-1:0] PHASE_MAIN_FIRST = 3'd4;
   localparam logic [PHASE_W-1:0] PHASE_LAST       = 3'd7;

   // One classified item: optional set-address byte, then the main byte.
   typedef struct packed {
      logic              has_addr;
      logic [BYTE_W-1:0] addr_byte;
      logic              is_data;
      logic [BYTE_W-1:0] main_byte;
   } cmd_type;

endpackage
`default_nettype wire

[src/char_lcd_nibble_writer_unit.sv]
// Top level of the character LCD nibble writer: front end, queue and phase sequencer.
//
// Each accepted item becomes pin phases for a 4-bit character LCD bus, one phase per
// response transfer: four phases for a raw control byte, a formatted-stream char or a
// positioned char that needs no set-address command, eight phases for a positioned char
// that needs a set-address command first, and none for opcode 3. The phase sequencer
// emits one phase per cycle unless the response stream stalls and is what sets the
// sustained rate; the queue in front of it (QUEUE_DEPTH commands) lets new items be
// accepted while it works. Each item is queued and then loaded before its first phase
// is registered out. Configuration is taken at once and has no read-back.
`default_nettype none
module char_lcd_nibble_writer_unit #(
   parameter int QUEUE_DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wen,
   input  wire logic [lcdnw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [lcdnw_pkg::BYTE_W-1:0]          csr_wdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // starts_string [0], position [8:1], value [16:9], zero [23:17]
   input  wire logic [lcdnw_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // opcode [1:0]
   input  wire logic [lcdnw_pkg::REQ_TUSER_W-1:0]     req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // bus_nibble [3:0], enable_level [4], wait_units [10:5], zero [15:11]
   output logic [lcdnw_pkg::RSP_TDATA_W-1:0]          rsp_tdata,
   // register_select [0]
   output logic [lcdnw_pkg::RSP_TUSER_W-1:0]          rsp_tuser,
   output logic                                       rsp_tlast
);
   import lcdnw_pkg::*;

   logic                item_fire;
   logic                cmd_push;
   cmd_type             cmd_front;
   logic                q_full, q_valid, q_pop;
   cmd_type             q_head;
   logic                out_rs, out_enable;
   logic [NIBBLE_W-1:0] out_nibble;
   logic [WAIT_W-1:0]   out_wait;

   assign req_tready = !q_full;
   assign item_fire  = req_tvalid && req_tready;

   lcdnw_front u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .item_fire     (item_fire),
      .item_opcode   (req_tuser[1:0]),
      .item_starts   (req_tdata[0]),
      .item_position (req_tdata[8:1]),
      .item_value    (req_tdata[16:9]),
      .cmd_push      (cmd_push),
      .cmd_out       (cmd_front)
   );

   lcdnw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_front),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_data  (q_head)
   );

   lcdnw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_data  (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_rs     (out_rs),
      .rsp_nibble (out_nibble),
      .rsp_enable (out_enable),
      .rsp_wait   (out_wait),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {5'd0, out_wait, out_enable, out_nibble};
   assign rsp_tuser = out_rs;

endmodule
`default_nettype wire

[src/lcdnw_front.sv]
// Front end: accepts items, tracks the cursor and classifies into byte commands.
`default_nettype none
module lcdnw_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_wen,
   input  wire logic [lcdnw_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lcdnw_pkg::BYTE_W-1:0]         csr_wdata,
   input  wire logic                                 item_fire,
   input  wire logic [1:0]                           item_opcode,
   input  wire logic                                 item_starts,
   input  wire logic [lcdnw_pkg::BYTE_W-1:0]         item_position,
   input  wire logic [lcdnw_pkg::BYTE_W-1:0]         item_value,
   output logic                                      cmd_push,
   output lcdnw_pkg::cmd_type                        cmd_out
);
   import lcdnw_pkg::*;

   logic [BYTE_W-1:0] line_two_start_ff, line_two_start_in;
   logic [BYTE_W-1:0] line_one_base_ff, line_one_base_in;
   logic [BYTE_W-1:0] line_two_base_ff, line_two_base_in;
   logic [BYTE_W-1:0] cursor_ff, cursor_in;
   logic              cursor_known_ff, cursor_known_in;

   opcode_type        op;
   logic              need_addr;
   logic [BYTE_W-1:0] addr_byte;
   logic [BYTE_W-1:0] cursor_base;

   assign op = opcode_type'(item_opcode);

   always_comb begin
      line_two_start_in = line_two_start_ff;
      line_one_base_in  = line_one_base_ff;
      line_two_base_in  = line_two_base_ff;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_LINE_TWO_START: line_two_start_in = csr_wdata;
            CSR_LINE_ONE_BASE:  line_one_base_in  = csr_wdata;
            CSR_LINE_TWO_BASE:  line_two_base_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      need_addr = item_starts && (!cursor_known_ff || cursor_ff != item_position);
      if (item_position < line_two_start_ff) begin
         addr_byte = line_one_base_ff + item_position;
      end else begin
         addr_byte = line_two_base_ff + item_position - line_two_start_ff;
      end
   end

   always_comb begin
      cmd_out.has_addr  = 1'b0;
      cmd_out.addr_byte = addr_byte;
      cmd_out.is_data   = 1'b1;
      cmd_out.main_byte = item_value;
      cmd_push          = item_fire;
      cursor_base       = need_addr ? item_position : cursor_ff;
      cursor_in         = cursor_ff;
      cursor_known_in   = cursor_known_ff;
      case (op)
         OP_POS_CHAR: begin
            cmd_out.has_addr = need_addr;
            if (item_fire) begin
               cursor_in       = cursor_base + 8'd1;
               cursor_known_in = cursor_known_ff | need_addr;
            end
         end
         OP_RAW_CTRL: begin
            cmd_out.is_data = 1'b0;
         end
         OP_STREAM_CHAR: begin
            if (item_value == CHAR_TAB) begin
               cmd_out.is_data   = 1'b0;
               cmd_out.main_byte = line_one_base_ff;
            end else if (item_value == CHAR_NEWLINE) begin
               cmd_out.is_data   = 1'b0;
               cmd_out.main_byte = line_two_base_ff;
            end
         end
         default: begin
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_two_start_ff <= LINE_TWO_START_RESET;
         line_one_base_ff  <= LINE_ONE_BASE_RESET;
         line_two_base_ff  <= LINE_TWO_BASE_RESET;
         cursor_ff         <= CURSOR_RESET;
         cursor_known_ff   <= 1'b0;
      end else begin
         line_two_start_ff <= line_two_start_in;
         line_one_base_ff  <= line_one_base_in;
         line_two_base_ff  <= line_two_base_in;
         cursor_ff         <= cursor_in;
         cursor_known_ff   <= cursor_known_in;
      end
   end

`ifndef SYNTHESIS
   // A starting positioned char always leaves the cursor known.
   assert property (@(posedge clock) disable iff (reset)
      item_fire && op == OP_POS_CHAR && item_starts |=> cursor_known_ff)
      else $error("cursor not known after a starting positioned char");
`endif

endmodule
`default_nettype wire

[src/lcdnw_queue.sv]
// Short command queue between the front end and the phase sequencer.
`default_nettype none
module lcdnw_queue #(
   parameter int DEPTH = lcdnw_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  lcdnw_pkg::cmd_type       push_data,
   input  wire logic                pop,
   output logic                     full,
   output logic                     head_valid,
   output lcdnw_pkg::cmd_type       head_data
);
   import lcdnw_pkg::*;

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == COUNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

[src/lcdnw_back.sv]
// Back end: turns queued commands to bus phases, one per cycle unless stalled.
`default_nettype none
module lcdnw_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              head_valid,
   input  lcdnw_pkg::cmd_type                     head_data,
   output logic                                   pop,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_rs,
   output logic [lcdnw_pkg::NIBBLE_W-1:0]         rsp_nibble,
   output logic                                   rsp_enable,
   output logic [lcdnw_pkg::WAIT_W-1:0]           rsp_wait,
   output logic                                   rsp_last
);
   import lcdnw_pkg::*;

   cmd_type            cur_ff, cur_in;
   logic               active_ff, active_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               valid_ff, valid_in;
   logic               rs_ff;
   logic [NIBBLE_W-1:0] nibble_ff;
   logic               enable_ff;
   logic [WAIT_W-1:0]  wait_ff;
   logic               last_ff;

   logic               out_free, emit, finish, load;
   logic [BYTE_W-1:0]  phase_byte;
   logic               phase_rs;
   logic [NIBBLE_W-1:0] phase_nibble;
   logic               phase_enable;
   logic [WAIT_W-1:0]  phase_wait;

   assign out_free = !valid_ff || rsp_tready;
   assign emit     = active_ff && out_free;
   assign finish   = emit && phase_ff == PHASE_LAST;
   // next command is taken in the cycle the last phase goes out, so no bubble
   assign load     = head_valid && (!active_ff || finish);
   assign pop      = load;

   // phase bit 2: address byte or main byte; bit 1: high or low nibble;
   // bit 0: EN high or EN low
   always_comb begin
      phase_byte   = phase_ff[2] ? cur_ff.main_byte : cur_ff.addr_byte;
      phase_rs     = phase_ff[2] & cur_ff.is_data;
      phase_nibble = phase_ff[1] ? phase_byte[NIBBLE_W-1:0] : phase_byte[BYTE_W-1:NIBBLE_W];
      phase_enable = !phase_ff[0];
      if (!phase_ff[0]) begin
         phase_wait = WAIT_NONE;
      end else if (phase_ff[1]) begin
         phase_wait = phase_rs ? WAIT_SHORT : WAIT_LONG;
      end else begin
         phase_wait = phase_rs ? WAIT_NONE : WAIT_SHORT;
      end
   end

   always_comb begin
      cur_in    = cur_ff;
      active_in = active_ff;
      phase_in  = phase_ff;
      if (load) begin
         cur_in    = head_data;
         active_in = 1'b1;
         phase_in  = head_data.has_addr ? PHASE_ADDR_FIRST : PHASE_MAIN_FIRST;
      end else if (finish) begin
         active_in = 1'b0;
      end else if (emit) begin
         phase_in = phase_ff + 1'b1;
      end
      if (emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
         phase_ff  <= PHASE_ADDR_FIRST;
      end else begin
         active_ff <= active_in;
         valid_ff  <= valid_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (emit) begin
         rs_ff     <= phase_rs;
         nibble_ff <= phase_nibble;
         enable_ff <= phase_enable;
         wait_ff   <= phase_wait;
         last_ff   <= (phase_ff == PHASE_LAST);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_rs     = rs_ff;
   assign rsp_nibble = nibble_ff;
   assign rsp_enable = enable_ff;
   assign rsp_wait   = wait_ff;
   assign rsp_last   = last_ff;

`ifndef SYNTHESIS
   // Without an address byte the sequencer never visits the address phases.
   assert property (@(posedge clock) disable iff (reset)
      active_ff && !cur_ff.has_addr |-> phase_ff[2])
      else $error("address phase for a command without address");

   // The final phase of a command is always an EN-low phase.
   assert property (@(posedge clock) disable iff (reset)
      valid_ff && last_ff |-> !enable_ff)
      else $error("last phase with EN high");

   // A new command is never loaded while the current one has phases left.
   assert property (@(posedge clock) disable iff (reset)
      pop |-> !active_ff || phase_ff == PHASE_LAST)
      else $error("command loaded mid-sequence");
`endif

endmodule
`default_nettype wire

[sim/char_lcd_nibble_writer_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the character LCD nibble writer: directed table, then random phases.
module char_lcd_nibble_writer_unit_tb;
   import lcdnw_pkg::*;

   // one pin phase as seen on the result stream
   typedef struct {
      logic                rs;
      logic [NIBBLE_W-1:0] nib;
      logic                en;
      logic [WAIT_W-1:0]   wt;
      logic                last;
   } pin_phase_type;

   // directed row; when typed, the byte sequence is written in by hand
   typedef struct {
      opcode_type        op;
      logic              starts;
      logic [BYTE_W-1:0] pos;
      logic [BYTE_W-1:0] val;
      bit                typed;
      int                nbytes;
      logic              first_data;
      logic [BYTE_W-1:0] first;
   } lcd_row_type;

   localparam int N_ROWS = 21;

   lcd_row_type lcd_rows [N_ROWS] = '{
      '{OP_POS_CHAR,    1'b1, 8'h00, 8'h41, 1'b1, 2, 1'b0, 8'h80},
      '{OP_POS_CHAR,    1'b1, 8'h01, 8'h42, 1'b1, 1, 1'b1, 8'h42},
      '{OP_POS_CHAR,    1'b0, 8'hFF, 8'hFF, 1'b1, 1, 1'b1, 8'hFF},
      '{OP_POS_CHAR,    1'b1, 8'h08, 8'h00, 1'b1, 2, 1'b0, 8'hC0},
      '{OP_POS_CHAR,    1'b1, 8'hFF, 8'h7E, 1'b1, 2, 1'b0, 8'hB7},
      '{OP_POS_CHAR,    1'b1, 8'h00, 8'h31, 1'b1, 1, 1'b1, 8'h31},
      '{OP_POS_CHAR,    1'b1, 8'h07, 8'h32, 1'b1, 2, 1'b0, 8'h87},
      '{OP_RAW_CTRL,    1'b0, 8'h00, 8'h01, 1'b1, 1, 1'b0, 8'h01},
      '{OP_RAW_CTRL,    1'b1, 8'hAA, 8'hFF, 1'b1, 1, 1'b0, 8'hFF},
      '{OP_RAW_CTRL,    1'b0, 8'hFF, 8'h00, 1'b1, 1, 1'b0, 8'h00},
      '{OP_STREAM_CHAR, 1'b1, 8'h55, 8'h09, 1'b1, 1, 1'b0, 8'h80},
      '{OP_STREAM_CHAR, 1'b0, 8'h00, 8'h0A, 1'b1, 1, 1'b0, 8'hC0},
      '{OP_STREAM_CHAR, 1'b0, 8'h00, 8'h41, 1'b1, 1, 1'b1, 8'h41},
      '{OP_STREAM_CHAR, 1'b0, 8'h00, 8'h00, 1'b1, 1, 1'b1, 8'h00},
      '{OP_STREAM_CHAR, 1'b1, 8'hFF, 8'hFF, 1'b1, 1, 1'b1, 8'hFF},
      '{OP_STREAM_CHAR, 1'b0, 8'h00, 8'h0B, 1'b0, 0, 1'b0, 8'h00},
      '{OP_UNUSED,      1'b1, 8'hFF, 8'hFF, 1'b1, 0, 1'b0, 8'h00},
      '{OP_UNUSED,      1'b0, 8'h00, 8'h00, 1'b1, 0, 1'b0, 8'h00},
      // cursor sits at 8 here, so no set-address
      '{OP_POS_CHAR,    1'b1, 8'h08, 8'h55, 1'b1, 1, 1'b1, 8'h55},
      '{OP_POS_CHAR,    1'b0, 8'h00, 8'h80, 1'b0, 0, 1'b0, 8'h00},
      '{OP_RAW_CTRL,    1'b0, 8'h00, 8'h28, 1'b0, 0, 1'b0, 8'h00}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_wen = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [BYTE_W-1:0]      csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;

   // predictor state and register copy
   logic [BYTE_W-1:0] two_start = LINE_TWO_START_RESET;
   logic [BYTE_W-1:0] one_base  = LINE_ONE_BASE_RESET;
   logic [BYTE_W-1:0] two_base  = LINE_TWO_BASE_RESET;
   logic [BYTE_W-1:0] cursor_pos = CURSOR_RESET;
   logic              cursor_known = 1'b0;

   pin_phase_type pending_phases [$];
   int            mismatches = 0;
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   logic          hold_rsp = 1'b0;

   char_lcd_nibble_writer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Works out the byte writes one item causes and advances the cursor.
   function automatic int plan_lcd_bytes(input opcode_type op, input logic starts,
                                         input logic [BYTE_W-1:0] pos,
                                         input logic [BYTE_W-1:0] val,
                                         output logic first_data,
                                         output logic [BYTE_W-1:0] first);
      int n;
      n = 0;
      first_data = 1'b1;
      first = val;
      case (op)
         OP_POS_CHAR: begin
            n = 1;
            if (starts && (!cursor_known || cursor_pos != pos)) begin
               n = 2;
               first_data = 1'b0;
               first = (pos < two_start) ? one_base + pos : two_base + pos - two_start;
               cursor_pos = pos;
               cursor_known = 1'b1;
            end
            cursor_pos = cursor_pos + 1'b1;
         end
         OP_RAW_CTRL: begin
            n = 1;
            first_data = 1'b0;
         end
         OP_STREAM_CHAR: begin
            n = 1;
            if (val == CHAR_TAB) begin
               first_data = 1'b0;
               first = one_base;
            end else if (val == CHAR_NEWLINE) begin
               first_data = 1'b0;
               first = two_base;
            end
         end
         default: n = 0;
      endcase
      return n;
   endfunction

   task automatic queue_byte_phases(input logic is_data, input logic [BYTE_W-1:0] b,
                                    input logic last);
      logic rs;
      rs = is_data;
      pending_phases.push_back('{rs, b[7:4], 1'b1, WAIT_NONE, 1'b0});
      pending_phases.push_back('{rs, b[7:4], 1'b0, is_data ? WAIT_NONE : WAIT_SHORT, 1'b0});
      pending_phases.push_back('{rs, b[3:0], 1'b1, WAIT_NONE, 1'b0});
      pending_phases.push_back('{rs, b[3:0], 1'b0, is_data ? WAIT_SHORT : WAIT_LONG, last});
   endtask

   task automatic queue_lcd_bytes(input int n, input logic first_data,
                                  input logic [BYTE_W-1:0] first,
                                  input logic [BYTE_W-1:0] val);
      if (n == 1) begin
         queue_byte_phases(first_data, first, 1'b1);
      end else if (n == 2) begin
         queue_byte_phases(1'b0, first, 1'b0);
         queue_byte_phases(1'b1, val, 1'b1);
      end
   endtask

   // Offers one item and returns at the edge where it is transferred.
   task automatic offer_item(input opcode_type op, input logic starts,
                             input logic [BYTE_W-1:0] pos, input logic [BYTE_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {7'd0, val, pos, starts};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_and_predict(input opcode_type op, input logic starts,
                                   input logic [BYTE_W-1:0] pos,
                                   input logic [BYTE_W-1:0] val);
      int n;
      logic fd;
      logic [BYTE_W-1:0] fb;
      offer_item(op, starts, pos, val);
      n = plan_lcd_bytes(op, starts, pos, val, fd, fb);
      queue_lcd_bytes(n, fd, fb, val);
   endtask

   // Wen stays high across the three writes and drops once.
   task automatic set_line_regs(input logic [BYTE_W-1:0] start2, input logic [BYTE_W-1:0] base1,
                                input logic [BYTE_W-1:0] base2);
      csr_wen <= 1'b1;
      csr_index <= CSR_LINE_TWO_START;
      csr_wdata <= start2;
      @(posedge clock);
      csr_index <= CSR_LINE_ONE_BASE;
      csr_wdata <= base1;
      @(posedge clock);
      csr_index <= CSR_LINE_TWO_BASE;
      csr_wdata <= base2;
      @(posedge clock);
      csr_wen <= 1'b0;
      two_start = start2;
      one_base = base1;
      two_base = base2;
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (pending_phases.size() != 0) @(posedge clock);
      // opcode 3 items leave no trace, give the pipeline time to empty
      repeat (16) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_phases
      pin_phase_type want;
      pin_phase_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{rsp_tuser[0], rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[10:5], rsp_tlast};
         if (pending_phases.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected phase rs=%b nib=%h en=%b wait=%0d last=%b",
                        $realtime, seen.rs, seen.nib, seen.en, seen.wt, seen.last);
         end else begin
            want = pending_phases.pop_front();
            if (seen.rs !== want.rs || seen.nib !== want.nib || seen.en !== want.en ||
                seen.wt !== want.wt || seen.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: phase mismatch exp rs=%b nib=%h en=%b wait=%0d last=%b",
                           $realtime, want.rs, want.nib, want.en, want.wt, want.last);
                  $display("%0t: phase mismatch got rs=%b nib=%h en=%b wait=%0d last=%b",
                           $realtime, seen.rs, seen.nib, seen.en, seen.wt, seen.last);
               end
            end
         end
      end
   end

   initial begin : stimulus
      int n;
      int sent;
      int r;
      logic fd;
      logic [BYTE_W-1:0] fb;
      opcode_type op;
      logic starts;
      logic [BYTE_W-1:0] pos;
      logic [BYTE_W-1:0] val;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset register values
      for (int i = 0; i < N_ROWS; i++) begin
         offer_item(lcd_rows[i].op, lcd_rows[i].starts, lcd_rows[i].pos, lcd_rows[i].val);
         n = plan_lcd_bytes(lcd_rows[i].op, lcd_rows[i].starts, lcd_rows[i].pos,
                            lcd_rows[i].val, fd, fb);
         if (lcd_rows[i].typed) begin
            n = lcd_rows[i].nbytes;
            fd = lcd_rows[i].first_data;
            fb = lcd_rows[i].first;
         end
         queue_lcd_bytes(n, fd, fb, lcd_rows[i].val);
      end
      wait_until_drained();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_line_regs(8'h00, 8'h00, 8'h00);
            1: set_line_regs(8'hFF, 8'hFF, 8'hFF);
            4: set_line_regs(LINE_TWO_START_RESET, LINE_ONE_BASE_RESET, LINE_TWO_BASE_RESET);
            default: set_line_regs(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 48; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 48; end
            default: begin send_idle_pct = 15; stall_pct <= 15; end
         endcase
         if (ph == 4) begin
            // long receiver hold-off so the queue fills and input backs up
            fork
               begin
                  hold_rsp <= 1'b1;
                  repeat (200) @(posedge clock);
                  hold_rsp <= 1'b0;
               end
            join_none
         end
         sent = 0;
         while (sent < 60) begin
            r = $urandom_range(99);
            if (r < 45) op = OP_POS_CHAR;
            else if (r < 65) op = OP_RAW_CTRL;
            else if (r < 92) op = OP_STREAM_CHAR;
            else op = OP_UNUSED;
            starts = 1'($urandom_range(1));
            pos = 8'($urandom);
            case ($urandom_range(3))
               0: pos = cursor_pos;
               1: pos = 8'(two_start + $urandom_range(2) - 1);
               default: ;
            endcase
            val = 8'($urandom);
            if (op == OP_STREAM_CHAR) begin
               r = $urandom_range(9);
               if (r < 2) val = CHAR_TAB;
               else if (r < 4) val = CHAR_NEWLINE;
            end
            send_and_predict(op, starts, pos, val);
            sent++;
         end
         wait_until_drained();
      end

      if (mismatches == 0 && pending_phases.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
